// File: src/dhrd_pkg.sv
// shared types and constants for the detection head row decoder
`default_nettype none

package dhrd_pkg;

   localparam int BOX_FIELDS = 4;
   localparam int HALF_Q16   = 32768;

   localparam int VAL_W   = 32;
   localparam int IDX_W   = 14;
   localparam int CLASS_W = 7;
   localparam int PIX_W   = 16;
   localparam int THR_W   = 17;
   localparam int PAD_W   = 12;
   localparam int SCALE_W = 16;
   localparam int NCLS_W  = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] CSR_CONF_THRESHOLD      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_INCLUSIVE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_X               = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_Y               = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE               = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_CLASSES         = 3'd5;

   localparam logic [THR_W-1:0]   THR_RESET   = 17'd16384;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
   localparam logic [NCLS_W-1:0]  NCLS_RESET  = 8'd80;

   localparam int FIFO_DEPTH = 2;

   localparam int RSP_DATA_W = 120;

   // one finished row on its way from the parser to the box unit
   typedef struct packed {
      logic [IDX_W-1:0]        index;
      logic [CLASS_W-1:0]      cls_idx;
      logic signed [VAL_W-1:0] score;
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] cy;
      logic signed [VAL_W-1:0] w;
      logic signed [VAL_W-1:0] h;
   } dhrd_rec_type;

   typedef struct packed {
      logic [THR_W-1:0]   conf_threshold;
      logic               threshold_inclusive;
      logic [PAD_W-1:0]   pad_x;
      logic [PAD_W-1:0]   pad_y;
      logic [SCALE_W-1:0] scale;
   } dhrd_cfg_type;

endpackage

`default_nettype wire

// File: src/dhrd_front.sv
// row parser: stores the box, keeps the running class argmax, counts rows
`default_nettype none

module dhrd_front
   import dhrd_pkg::*;
#(
   parameter int MAX_CLASSES = 128,
   parameter int MAX_ROWS    = 16384
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [VAL_W-1:0] in_value,
   input  wire logic [NCLS_W-1:0]       num_classes,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output dhrd_rec_type                 push_rec
);

   localparam int CLS_CAP = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
   localparam int POS_W   = $clog2(CLS_CAP + BOX_FIELDS);
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] box_ff [BOX_FIELDS];
   logic signed [VAL_W-1:0] best_score_ff, best_score_in;
   logic [CLASS_W-1:0]      best_class_ff, best_class_in;
   logic [ROW_W-1:0]        row_count_ff, row_count_in;

   logic [NCLS_W-1:0] ncls;
   logic [POS_W-1:0]  last_pos;
   logic              in_box;
   logic              row_end;
   logic              take;
   logic              accept;
   logic [CLASS_W-1:0] cls;

   always_comb begin
      if (num_classes == '0) begin
         ncls = NCLS_W'(1);
      end else if (num_classes > NCLS_W'(CLS_CAP)) begin
         ncls = NCLS_W'(CLS_CAP);
      end else begin
         ncls = num_classes;
      end
   end

   assign last_pos = POS_W'(int'(ncls) + BOX_FIELDS - 1);
   assign in_box   = pos_ff < POS_W'(BOX_FIELDS);
   assign row_end  = !in_box && (pos_ff >= last_pos);
   assign cls      = CLASS_W'(pos_ff - POS_W'(BOX_FIELDS));
   // first score of the row always loads; later ones only on a strict win
   assign take     = (pos_ff == POS_W'(BOX_FIELDS)) || (in_value > best_score_ff);

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   assign best_score_in = take ? in_value : best_score_ff;
   assign best_class_in = take ? cls : best_class_ff;

   always_comb begin
      pos_in       = pos_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (row_end) begin
            pos_in = '0;
            if (row_count_ff == ROW_W'(MAX_ROWS - 1)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         row_count_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         row_count_ff <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_box) begin
         box_ff[pos_ff[1:0]] <= in_value;
      end
      if (accept && !in_box) begin
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
      end
   end

   assign push_valid        = accept && row_end;
   assign push_rec.index    = IDX_W'(row_count_ff);
   assign push_rec.cls_idx  = best_class_in;
   assign push_rec.score    = best_score_in;
   assign push_rec.cx       = box_ff[0];
   assign push_rec.cy       = box_ff[1];
   assign push_rec.w        = box_ff[2];
   assign push_rec.h        = box_ff[3];

endmodule

`default_nettype wire

// File: src/dhrd_fifo.sv
// short queue of finished rows between parser and box unit
`default_nettype none

module dhrd_fifo
   import dhrd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire dhrd_rec_type  push_rec,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output dhrd_rec_type       pop_rec
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   dhrd_rec_type     slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_rec    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// File: src/dhrd_back.sv
// box unit: threshold test, padding removal, scaling and clamping of kept rows
`default_nettype none

module dhrd_back
   import dhrd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dhrd_cfg_type     cfg,
   input  wire logic             q_valid,
   output logic                  q_ready,
   input  wire dhrd_rec_type     q_rec,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [RSP_DATA_W-1:0] out_data
);

   localparam int TWICE_W    = 34;
   localparam int PROD_W     = TWICE_W + SCALE_W + 1;
   localparam int EDGE_FRAC  = 25;
   localparam int SIZE_FRAC  = 24;
   localparam int PAD_SHIFT  = 17;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_MUL  = 3'b010,
      BK_OUT  = 3'b100
   } bk_state_type;

   bk_state_type state_ff, state_in;

   logic [IDX_W-1:0]          index_ff;
   logic [CLASS_W-1:0]        class_ff;
   logic signed [VAL_W-1:0]   score_ff;
   logic signed [TWICE_W-1:0] twice_x_ff, twice_y_ff;
   logic signed [TWICE_W-1:0] twice_x_in, twice_y_in;
   logic signed [VAL_W-1:0]   w_ff, h_ff;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_w_ff, prod_h_ff;
   logic signed [SCALE_W:0]   scale_s;
   logic signed [VAL_W:0]     score_e;
   logic signed [VAL_W:0]     thr_e;
   logic                      keep;
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]     out_data_ff;
   logic                      load_out;

   // arithmetic shift already applied; negative gives zero, overflow saturates
   function automatic logic [PIX_W-1:0] pix_sat(input logic signed [PROD_W-1:0] v);
      logic [PIX_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > PROD_W'({PIX_W{1'b1}})) begin
         r = '1;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

   assign scale_s = $signed({1'b0, cfg.scale});
   assign score_e = {q_rec.score[VAL_W-1], q_rec.score};
   assign thr_e   = $signed({{(VAL_W - THR_W + 1){1'b0}}, cfg.conf_threshold});
   assign keep    = cfg.threshold_inclusive ? (score_e >= thr_e) : (score_e > thr_e);

   // twice the edge in Q16.16: 2c - s + 1.0 - 2 pad
   assign twice_x_in = (TWICE_W'(q_rec.cx) <<< 1) - TWICE_W'(q_rec.w)
                     + TWICE_W'(2 * HALF_Q16)
                     - $signed(TWICE_W'(cfg.pad_x) <<< PAD_SHIFT);
   assign twice_y_in = (TWICE_W'(q_rec.cy) <<< 1) - TWICE_W'(q_rec.h)
                     + TWICE_W'(2 * HALF_Q16)
                     - $signed(TWICE_W'(cfg.pad_y) <<< PAD_SHIFT);

   assign q_ready  = state_ff == BK_IDLE;
   assign load_out = (state_ff == BK_OUT) && (!out_valid_ff || out_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && keep) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (load_out) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && q_valid) begin
         index_ff   <= q_rec.index;
         class_ff   <= q_rec.cls_idx;
         score_ff   <= q_rec.score;
         twice_x_ff <= twice_x_in;
         twice_y_ff <= twice_y_in;
         w_ff       <= q_rec.w;
         h_ff       <= q_rec.h;
      end
      if (state_ff == BK_MUL) begin
         prod_x_ff <= PROD_W'(twice_x_ff) * PROD_W'(scale_s);
         prod_y_ff <= PROD_W'(twice_y_ff) * PROD_W'(scale_s);
         prod_w_ff <= PROD_W'(w_ff) * PROD_W'(scale_s);
         prod_h_ff <= PROD_W'(h_ff) * PROD_W'(scale_s);
      end
      if (load_out) begin
         out_data_ff <= {3'b000,
                         pix_sat(prod_h_ff >>> SIZE_FRAC),
                         pix_sat(prod_w_ff >>> SIZE_FRAC),
                         pix_sat(prod_y_ff >>> EDGE_FRAC),
                         pix_sat(prod_x_ff >>> EDGE_FRAC),
                         score_ff,
                         class_ff,
                         index_ff};
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// File: src/detection_head_row_decoder_core.sv
// top level of the detection head row decoder
//
//   channel  dir  width  carries
//   req_     in   32     one row element per transfer
//   rsp_     out  120    one kept candidate per transfer
//   csr_     in   3+17   register index and write data
//
// one row element per cycle at req_; req_tready drops only while the
// two-entry row queue is full. a kept row is summed on dequeue, then
// multiplied, then clamped when rsp_ is free; a dropped row is only dequeued.
// a row has at least five elements, so the box unit keeps pace with input.
// reset is synchronous and restores the register reset values at once.
`default_nettype none

module detection_head_row_decoder_core
   import dhrd_pkg::*;
#(
   parameter int MAX_CLASSES = 128,
   parameter int MAX_ROWS    = 16384
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [31:0] value
   input  wire logic [VAL_W-1:0]      req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [13:0] candidate_index, [20:14] class number, [52:21] confidence,
   // [68:53] box_left, [84:69] box_top, [100:85] box_width,
   // [116:101] box_height, [119:117] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   dhrd_cfg_type      cfg_ff, cfg_in;
   logic [NCLS_W-1:0] ncls_ff, ncls_in;

   logic         push_valid, push_ready;
   dhrd_rec_type push_rec;
   logic         pop_valid, pop_ready;
   dhrd_rec_type pop_rec;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in  = cfg_ff;
      ncls_in = ncls_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONF_THRESHOLD:      cfg_in.conf_threshold      = csr_data[THR_W-1:0];
            CSR_THRESHOLD_INCLUSIVE: cfg_in.threshold_inclusive = csr_data[0];
            CSR_PAD_X:               cfg_in.pad_x               = csr_data[PAD_W-1:0];
            CSR_PAD_Y:               cfg_in.pad_y               = csr_data[PAD_W-1:0];
            CSR_SCALE:               cfg_in.scale               = csr_data[SCALE_W-1:0];
            CSR_NUM_CLASSES:         ncls_in                    = csr_data[NCLS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_threshold      <= THR_RESET;
         cfg_ff.threshold_inclusive <= 1'b0;
         cfg_ff.pad_x               <= '0;
         cfg_ff.pad_y               <= '0;
         cfg_ff.scale               <= SCALE_RESET;
         ncls_ff                    <= NCLS_RESET;
      end else begin
         cfg_ff  <= cfg_in;
         ncls_ff <= ncls_in;
      end
   end

   dhrd_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_value    ($signed(req_tdata)),
      .num_classes (ncls_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_rec    (push_rec)
   );

   dhrd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   dhrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (pop_valid),
      .q_ready   (pop_ready),
      .q_rec     (pop_rec),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: src/dhrd_checker.sv
// port-level checks for the detection head row decoder, bound to the top level
`default_nettype none

module dhrd_checker
   import dhrd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a waiting result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a waiting result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // nothing is offered in the cycle after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // pad bits above the last field are always zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:117] == '0)
      else $error("nonzero pad bits in result");

endmodule

bind detection_head_row_decoder_core dhrd_checker u_dhrd_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking testbench for the detection head row decoder core
`timescale 1ns / 100ps

module tb_top
   import dhrd_pkg::*;
();

   localparam int MAX_CLASSES = 128;
   localparam int MAX_ROWS    = 16384;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 10;

   typedef struct {
      logic [IDX_W-1:0]   index;
      logic [CLASS_W-1:0] cls_idx;
      logic [VAL_W-1:0]   score;
      logic [PIX_W-1:0]   left;
      logic [PIX_W-1:0]   top;
      logic [PIX_W-1:0]   width;
      logic [PIX_W-1:0]   height;
   } cand_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VAL_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // register copies
   logic [THR_W-1:0]   thr_r;
   logic               incl_r;
   logic [PAD_W-1:0]   padx_r;
   logic [PAD_W-1:0]   pady_r;
   logic [SCALE_W-1:0] scale_r;
   logic [NCLS_W-1:0]  ncls_r;

   // row state
   int unsigned             elem_pos;
   logic signed [VAL_W-1:0] box_v [BOX_FIELDS];
   logic signed [VAL_W-1:0] best_score;
   logic [CLASS_W-1:0]      best_class;
   int unsigned             row_count;

   cand_type cand_q[$];

   int    errors;
   int    cycle_count;
   bit    src_idle_en;
   bit    sink_idle_en;
   int    hold_request;

   detection_head_row_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // ---------------- prediction ----------------

   function automatic logic [PIX_W-1:0] clamp_pixels(input longint prod, input int frac);
      longint r;
      if (prod <= 0)
         return '0;
      r = prod >>> frac;
      if (r > 65535)
         return 16'hFFFF;
      return r[PIX_W-1:0];
   endfunction

   // edge at twice the Q16.16 scale so the half-size and half-pixel terms stay exact
   function automatic logic [PIX_W-1:0] edge_pixels(input logic signed [VAL_W-1:0] centre,
                                                   input logic signed [VAL_W-1:0] size,
                                                   input logic [PAD_W-1:0] pad);
      longint twice;
      twice = 2 * longint'(centre) - longint'(size) + 2 * longint'(HALF_Q16)
              - 2 * longint'(pad) * 65536;
      return clamp_pixels(twice * longint'(scale_r), 25);
   endfunction

   function automatic int unsigned class_count(input logic [NCLS_W-1:0] n);
      if (n == 0)
         return 1;
      if (n > MAX_CLASSES)
         return MAX_CLASSES;
      return int'(n);
   endfunction

   task automatic reset_decoder();
      thr_r      = THR_RESET;
      incl_r     = 1'b0;
      padx_r     = '0;
      pady_r     = '0;
      scale_r    = SCALE_RESET;
      ncls_r     = NCLS_RESET;
      elem_pos   = 0;
      for (int i = 0; i < BOX_FIELDS; i++)
         box_v[i] = '0;
      best_score = '0;
      best_class = '0;
      row_count  = 0;
   endtask

   task automatic decode_element(input logic signed [VAL_W-1:0] v);
      int unsigned last;
      int unsigned cls;
      logic        keep;
      cand_type    c;
      last = BOX_FIELDS + class_count(ncls_r) - 1;
      if (elem_pos < BOX_FIELDS) begin
         box_v[elem_pos[1:0]] = v;
         elem_pos++;
         return;
      end
      cls = elem_pos - BOX_FIELDS;
      if (cls == 0 || v > best_score) begin
         best_score = v;
         best_class = cls[CLASS_W-1:0];
      end
      if (elem_pos < last) begin
         elem_pos++;
         return;
      end
      // row end, the counter moves on whether or not the row is kept
      elem_pos   = 0;
      c.index    = row_count[IDX_W-1:0];
      row_count  = (row_count + 1 >= MAX_ROWS) ? 0 : row_count + 1;
      if (incl_r)
         keep = longint'(best_score) >= longint'(thr_r);
      else
         keep = longint'(best_score) > longint'(thr_r);
      if (!keep)
         return;
      c.cls_idx  = best_class;
      c.score    = best_score;
      c.left     = edge_pixels(box_v[0], box_v[2], padx_r);
      c.top      = edge_pixels(box_v[1], box_v[3], pady_r);
      c.width    = clamp_pixels(longint'(box_v[2]) * longint'(scale_r), 24);
      c.height   = clamp_pixels(longint'(box_v[3]) * longint'(scale_r), 24);
      cand_q = {cand_q, c};
   endtask

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic compare_field(input string what, input logic [VAL_W-1:0] got,
                                input logic [VAL_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      cand_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cand_q.size() == 0) begin
            report_mismatch("unexpected candidate", rsp_tdata[31:0], '0);
         end else begin
            want = cand_q.pop_front();
            compare_field("candidate_index", VAL_W'(rsp_tdata[13:0]), VAL_W'(want.index));
            compare_field("class number", VAL_W'(rsp_tdata[20:14]), VAL_W'(want.cls_idx));
            compare_field("confidence", rsp_tdata[52:21], want.score);
            compare_field("box_left", VAL_W'(rsp_tdata[68:53]), VAL_W'(want.left));
            compare_field("box_top", VAL_W'(rsp_tdata[84:69]), VAL_W'(want.top));
            compare_field("box_width", VAL_W'(rsp_tdata[100:85]), VAL_W'(want.width));
            compare_field("box_height", VAL_W'(rsp_tdata[116:101]), VAL_W'(want.height));
            compare_field("pad bits", VAL_W'(rsp_tdata[119:117]), '0);
         end
      end
   end

   // ---------------- result sink ----------------

   initial begin : sink
      int n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            // long hold-off so the row queue fills and input stalls
            n = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_value(input logic [VAL_W-1:0] v);
      if (src_idle_en && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      decode_element(v);
   endtask

   task automatic send_box(input logic [VAL_W-1:0] cx, input logic [VAL_W-1:0] cy,
                           input logic [VAL_W-1:0] w, input logic [VAL_W-1:0] h);
      send_value(cx);
      send_value(cy);
      send_value(w);
      send_value(h);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CONF_THRESHOLD:      thr_r   = d[THR_W-1:0];
         CSR_THRESHOLD_INCLUSIVE: incl_r  = d[0];
         CSR_PAD_X:               padx_r  = d[PAD_W-1:0];
         CSR_PAD_Y:               pady_r  = d[PAD_W-1:0];
         CSR_SCALE:               scale_r = d[SCALE_W-1:0];
         CSR_NUM_CLASSES:         ncls_r  = d[NCLS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [THR_W-1:0] thr, input logic incl,
                            input logic [PAD_W-1:0] px, input logic [PAD_W-1:0] py,
                            input logic [SCALE_W-1:0] sc, input logic [NCLS_W-1:0] n);
      write_reg(CSR_CONF_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(CSR_THRESHOLD_INCLUSIVE, CSR_DATA_W'(incl));
      write_reg(CSR_PAD_X, CSR_DATA_W'(px));
      write_reg(CSR_PAD_Y, CSR_DATA_W'(py));
      write_reg(CSR_SCALE, CSR_DATA_W'(sc));
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(n));
   endtask

   // drain all expected candidates, then give a dropped row time to retire
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (cand_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] rand_box();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return -($urandom_range(0, 50) << 16);
         default: return ($urandom_range(0, 700) << 16) | $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] rand_score(input logic [THR_W-1:0] thr);
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return VAL_W'(thr) + $urandom_range(0, 4) - 2;
         2:       return $urandom_range(0, 3) * 16384;
         default: return $urandom_range(0, 131072);
      endcase
   endfunction

   task automatic send_random_row();
      int unsigned n;
      n = class_count(ncls_r);
      for (int i = 0; i < BOX_FIELDS; i++)
         send_value(rand_box());
      for (int i = 0; i < n; i++)
         send_value(rand_score(thr_r));
   endtask

   // ---------------- tests ----------------

   // threshold and scale at their reset values, strict compare
   task automatic test_defaults();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(1));
      send_box(32'h0064_0000, 32'h0050_0000, 32'h0014_0000, 32'h000A_0000);
      send_value(32'd16385);
      send_box(32'h0064_8000, 32'h0050_4000, 32'h0014_C000, 32'h000A_2000);
      send_value(32'd16384);
      wait_idle();
   endtask

   task automatic test_extremes();
      write_all(17'd65536, 1'b1, 12'd4095, 12'd0, 16'hFFFF, 8'd2);
      // ties keep the first class, saturating box
      send_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_value(32'h0001_0000);
      send_value(32'h0001_0000);
      // negative box clamps to zero, later class wins
      send_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      wait_idle();
      write_all(17'd0, 1'b0, 12'd0, 12'd4095, 16'd0, 8'd2);
      send_box(32'h0010_0000, 32'h0010_0000, 32'h0004_0000, 32'h0004_0000);
      send_value(32'd1);
      send_value(32'd0);
      send_box(32'h0010_0000, 32'h0010_0000, 32'h0004_0000, 32'h0004_0000);
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      wait_idle();
   endtask

   task automatic test_class_count();
      write_all(17'd0, 1'b1, 12'd3, 12'd7, 16'd300, 8'd0);
      // zero classes acts as one
      send_box(32'h0020_0000, 32'h0030_0000, 32'h0008_0000, 32'h0006_0000);
      send_value(32'h0000_4000);
      wait_idle();
      // above the maximum acts as the maximum
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(200));
      send_random_row();
      wait_idle();
      // count shrunk mid row: the next score ends it
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(10));
      send_box(32'h0040_0000, 32'h0040_0000, 32'h0010_0000, 32'h0010_0000);
      for (int i = 0; i < 6; i++)
         send_value(32'(i * 1000));
      wait_idle();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(3));
      send_value(32'h0000_0100);
      wait_idle();
      // count grown mid row: the row runs on
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(2));
      send_box(32'h0050_0000, 32'h0050_0000, 32'h0010_0000, 32'h0010_0000);
      send_value(32'h0000_0200);
      wait_idle();
      write_reg(CSR_NUM_CLASSES, CSR_DATA_W'(5));
      for (int i = 0; i < 4; i++)
         send_value(32'h0000_0300 - 32'(i));
      wait_idle();
   endtask

   task automatic test_random_rows();
      logic [THR_W-1:0]   thr;
      logic [PAD_W-1:0]   px;
      logic [PAD_W-1:0]   py;
      logic [SCALE_W-1:0] sc;
      logic [NCLS_W-1:0]  n;
      int                 sent;
      for (int p = 0; p < 7; p++) begin
         case ($urandom_range(0, 5))
            0:       thr = 17'd0;
            1:       thr = 17'd65536;
            default: thr = THR_W'($urandom_range(0, 65536));
         endcase
         px = ($urandom_range(0, 3) == 0) ? PAD_W'($urandom_range(0, 4095))
                                          : PAD_W'($urandom_range(0, 80));
         py = ($urandom_range(0, 3) == 0) ? PAD_W'($urandom_range(0, 4095))
                                          : PAD_W'($urandom_range(0, 80));
         case (p)
            0:       sc = 16'd0;
            1:       sc = 16'hFFFF;
            default: sc = ($urandom_range(0, 3) == 0) ? 16'd256
                                                      : SCALE_W'($urandom_range(64, 1024));
         endcase
         if (p == 5)
            n = 8'd128;
         else if ($urandom_range(0, 3) == 0)
            n = NCLS_W'($urandom_range(7, 24));
         else
            n = NCLS_W'($urandom_range(1, 6));
         write_all(thr, 1'($urandom_range(0, 1)), px, py, sc, n);
         src_idle_en  = ($urandom_range(0, 3) != 0);
         sink_idle_en = ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < 100) begin
            send_random_row();
            sent += BOX_FIELDS + class_count(n);
         end
         wait_idle();
      end
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
   endtask

   task automatic test_backpressure();
      write_all(17'd0, 1'b1, 12'd1, 12'd2, 16'd512, 8'd1);
      hold_request = 400;
      for (int i = 0; i < 40; i++) begin
         send_box(rand_box(), rand_box(), rand_box(), rand_box());
         send_value(32'h0001_0000 + 32'(i));
      end
      wait_idle();
   endtask

   // back to back rows with no idling on either side
   task automatic test_steady_stream();
      write_all(17'd32768, 1'b0, 12'd0, 12'd0, 16'd256, 8'd1);
      for (int i = 0; i < 30; i++) begin
         send_box(rand_box(), rand_box(), rand_box(), rand_box());
         send_value(rand_score(thr_r));
      end
      wait_idle();
   endtask

   initial begin
      errors       = 0;
      cycle_count  = 0;
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      hold_request = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      reset_decoder();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_extremes();
      test_class_count();
      test_random_rows();
      test_backpressure();
      test_steady_stream();

      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// File: files.f
src/dhrd_pkg.sv
src/dhrd_front.sv
src/dhrd_fifo.sv
src/dhrd_back.sv
src/detection_head_row_decoder_core.sv
src/dhrd_checker.sv
tb/sv/tb_top.sv
